/* rtl/core/ptpms_pkg.sv */
// Shared types and constants for the point-to-point motion stepper.
package ptpms_pkg;

	localparam int CordicIter = 16;
	localparam int IterW = $clog2(CordicIter + 1);
	localparam logic [29:0] CordicKinv = 30'd652032874;
	localparam logic [23:0] StepReset = 24'd6554;
	localparam int VecW = 36;
	localparam int RotW = 26;

	typedef enum logic [1:0] {
		MODE_GOAL = 2'd0,
		MODE_TICK = 2'd1,
		MODE_CANCEL = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_ACCEPTED = 3'd1,
		ST_MOVING = 3'd2,
		ST_REACHED = 3'd3,
		ST_PREEMPTED = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_LOAD,
		CS_ITER,
		CS_MAG,
		CS_DECIDE,
		CS_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic goal_load;
		logic tick_load;
		logic iter_en;
		logic mag_en;
		logic snap;
		logic advance;
		logic drop;
	} dp_cmd_t;

	typedef struct packed {
		logic at_goal;
		logic goal_active;
		logic iter_done;
		logic mag_below;
	} dp_stat_t;

	typedef struct packed {
		logic [1:0] mode;
		logic signed [31:0] goal_x;
		logic signed [31:0] goal_y;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [2:0] status;
	} out_word_t;

endpackage

/* rtl/core/ptpms_if.sv */
// Valid/ready channel interfaces for input and result words.
interface ptpms_in_if;
	import ptpms_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] mode;
	logic signed [31:0] goal_x;
	logic signed [31:0] goal_y;
	modport source (output valid, output mode, output goal_x, output goal_y, input ready);
	modport sink (input valid, input mode, input goal_x, input goal_y, output ready);
endinterface

interface ptpms_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [2:0] status;
	modport source (output valid, output pos_x, output pos_y, output status, input ready);
	modport sink (input valid, input pos_x, input pos_y, input status, output ready);
endinterface

/* rtl/core/point_to_point_motion_stepper.sv */
// Point-to-point motion stepper: top level.
// Steps from input accept to result: cancel and idle words go straight to output, goal
// words through load and output, tick words through load, 16 CORDIC iterations on one
// shared unit, iteration done, magnitude, decide and output.
// One word at a time; the next word is accepted in the cycle after the result is taken.
// Reset: arst_n clears position, target and goal; step_length returns to 6554.
module point_to_point_motion_stepper (
	input  logic clk,
	input  logic arst_n,
	ptpms_in_if.sink in_ch,
	ptpms_out_if.source out_ch,
	input  logic cfg_we,
	input  logic [23:0] cfg_wdata
);
	import ptpms_pkg::*;

	logic [23:0] step_q;
	in_word_t in_word;
	dp_cmd_t cmd;
	dp_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) step_q <= StepReset;
		else if (cfg_we) step_q <= cfg_wdata;
	end

	assign in_word.mode = in_ch.mode;
	assign in_word.goal_x = in_ch.goal_x;
	assign in_word.goal_y = in_ch.goal_y;

	ptpms_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_mode(in_ch.mode),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_status(out_ch.status),
		.stat(stat), .cmd(cmd)
	);

	ptpms_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_word(in_word), .step_length(step_q),
		.cmd(cmd), .stat(stat), .pos_x(out_ch.pos_x), .pos_y(out_ch.pos_y)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid)) else $error("accept during output");
	a_reached_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status == ST_REACHED) |-> !stat.goal_active)
		else $error("reached with goal active");
	a_moving_active: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status == ST_MOVING) |-> stat.goal_active)
		else $error("moving without goal");

endmodule

/* rtl/core/ptpms_datapath.sv */
// Position, target and shared CORDIC datapath of the motion stepper.
module ptpms_datapath (
	input  logic clk,
	input  logic arst_n,
	input  ptpms_pkg::in_word_t in_word,
	input  logic [23:0] step_length,
	input  ptpms_pkg::dp_cmd_t cmd,
	output ptpms_pkg::dp_stat_t stat,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y
);
	import ptpms_pkg::*;

	logic signed [31:0] px_q, py_q, tx_q, ty_q;
	logic active_q;
	logic flip_q;
	logic signed [VecW-1:0] vx_q, vy_q;
	logic signed [RotW-1:0] rx_q, ry_q;
	logic [IterW-1:0] it_q;
	logic [23:0] step_q;
	logic below_q;

	logic signed [32:0] dx, dy, adx, ady;
	logic [23:0] step_eff;
	logic [53:0] rot_init;
	logic signed [VecW-1:0] vsx, vsy;
	logic signed [RotW-1:0] rsx, rsy;
	logic [VecW+29:0] mag_full;
	logic [VecW-1:0] vx_pos;
	logic signed [RotW-1:0] rfx, rfy;
	logic signed [33:0] nx, ny;

	assign dx = 33'(tx_q) - 33'(px_q);
	assign dy = 33'(ty_q) - 33'(py_q);
	assign adx = dx[32] ? -dx : dx;
	assign ady = dx[32] ? -dy : dy;
	assign step_eff = (step_length == 24'd0) ? 24'd1 : step_length;
	assign rot_init = 54'(step_eff) * 54'(CordicKinv);
	assign vsx = vx_q >>> it_q;
	assign vsy = vy_q >>> it_q;
	assign rsx = rx_q >>> it_q;
	assign rsy = ry_q >>> it_q;
	assign vx_pos = vx_q[VecW-1] ? '0 : vx_q;
	assign mag_full = (VecW+30)'(vx_pos) * (VecW+30)'(CordicKinv);
	assign rfx = flip_q ? -rx_q : rx_q;
	assign rfy = flip_q ? -ry_q : ry_q;
	assign nx = 34'(px_q) + 34'(rfx);
	assign ny = 34'(py_q) + 34'(rfy);

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647) return 32'sh7fffffff;
		if (v < -34'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0;
			py_q <= '0;
			tx_q <= '0;
			ty_q <= '0;
			active_q <= 1'b0;
			flip_q <= 1'b0;
			vx_q <= '0;
			vy_q <= '0;
			rx_q <= '0;
			ry_q <= '0;
			step_q <= '0;
			below_q <= 1'b0;
			it_q <= '0;
		end else begin
			if (cmd.goal_load) begin
				tx_q <= in_word.goal_x;
				ty_q <= in_word.goal_y;
				active_q <= !(in_word.goal_x == px_q && in_word.goal_y == py_q);
			end
			if (cmd.tick_load) begin
				flip_q <= dx[32];
				vx_q <= VecW'(adx);
				vy_q <= VecW'(ady);
				rx_q <= RotW'(rot_init[53:30]);
				ry_q <= '0;
				step_q <= step_eff;
				it_q <= '0;
			end
			if (cmd.iter_en) begin
				if (!vy_q[VecW-1]) begin
					vx_q <= vx_q + vsy;
					vy_q <= vy_q - vsx;
					rx_q <= rx_q - rsy;
					ry_q <= ry_q + rsx;
				end else begin
					vx_q <= vx_q - vsy;
					vy_q <= vy_q + vsx;
					rx_q <= rx_q + rsy;
					ry_q <= ry_q - rsx;
				end
				it_q <= it_q + 1'b1;
			end
			if (cmd.mag_en) begin
				below_q <= mag_full[VecW+29:30] < (VecW)'(step_q);
			end
			if (cmd.snap) begin
				px_q <= tx_q;
				py_q <= ty_q;
				active_q <= 1'b0;
			end
			if (cmd.advance) begin
				px_q <= sat32(nx);
				py_q <= sat32(ny);
			end
			if (cmd.drop) begin
				active_q <= 1'b0;
			end
		end
	end

	assign stat.at_goal = (tx_q == px_q) && (ty_q == py_q);
	assign stat.goal_active = active_q;
	assign stat.iter_done = (it_q == IterW'(CordicIter));
	assign stat.mag_below = below_q;
	assign pos_x = px_q;
	assign pos_y = py_q;

endmodule

/* rtl/core/ptpms_ctrl.sv */
// Controller state machine for the motion stepper.
module ptpms_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] in_mode,
	output logic out_valid,
	input  logic out_ready,
	output logic [2:0] out_status,
	input  ptpms_pkg::dp_stat_t stat,
	output ptpms_pkg::dp_cmd_t cmd
);
	import ptpms_pkg::*;

	ctrl_state_t state_q, state_d;
	status_t status_q, status_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			status_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
			status_q <= status_d;
		end
	end

	always_comb begin
		state_d = state_q;
		status_d = status_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			CS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = CS_OUT;
					unique case (mode_t'(in_mode))
						MODE_GOAL: begin
							cmd.goal_load = 1'b1;
							state_d = CS_LOAD;
						end
						MODE_TICK: begin
							if (stat.goal_active) begin
								cmd.tick_load = 1'b1;
								state_d = CS_ITER;
							end else begin
								status_d = ST_IDLE;
							end
						end
						MODE_CANCEL: begin
							if (stat.goal_active) begin
								cmd.drop = 1'b1;
								status_d = ST_PREEMPTED;
							end else begin
								status_d = ST_IDLE;
							end
						end
						default: status_d = ST_IDLE;
					endcase
				end
			end
			CS_LOAD: begin
				status_d = stat.goal_active ? ST_ACCEPTED : ST_REACHED;
				state_d = CS_OUT;
			end
			CS_ITER: begin
				if (stat.iter_done) begin
					state_d = CS_MAG;
				end else begin
					cmd.iter_en = 1'b1;
				end
			end
			CS_MAG: begin
				cmd.mag_en = 1'b1;
				state_d = CS_DECIDE;
			end
			CS_DECIDE: begin
				if (stat.mag_below) begin
					cmd.snap = 1'b1;
					status_d = ST_REACHED;
				end else begin
					cmd.advance = 1'b1;
					status_d = ST_MOVING;
				end
				state_d = CS_OUT;
			end
			CS_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = CS_IDLE;
			end
			default: state_d = CS_IDLE;
		endcase
	end

	assign out_status = status_q;

endmodule

/* dv/tb_point_to_point_motion_stepper.sv */
// Testbench for the motion stepper: predicts every result word and checks it.
`timescale 1ns / 1ps
module tb_point_to_point_motion_stepper;
	import ptpms_pkg::*;

	typedef struct {
		logic [1:0] mode;
		logic signed [31:0] gx;
		logic signed [31:0] gy;
		logic chk;
		logic signed [31:0] ex;
		logic signed [31:0] ey;
		logic [2:0] est;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [23:0] cfg_wdata = '0;

	ptpms_in_if in_ch ();
	ptpms_out_if out_ch ();

	point_to_point_motion_stepper uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	longint mdl_px, mdl_py, mdl_tx, mdl_ty;
	bit mdl_active;
	logic [23:0] mdl_step;
	out_word_t expected_q[$];
	int errors = 0;
	int cycles = 0;
	int snd_idle = 0;
	int rcv_idle = 0;
	int hold_cycles = 0;
	localparam int Limit = 4000000;

	function automatic longint asr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic [2:0] step_toward_goal();
		longint dx, dy, vx, vy, rx, ry, nx, ny, stp, kinv;
		longint unsigned mag;
		bit flip;
		dx = mdl_tx - mdl_px;
		dy = mdl_ty - mdl_py;
		kinv = longint'(CordicKinv);
		stp = (mdl_step == 0) ? 1 : longint'(mdl_step);
		flip = dx < 0;
		if (flip) begin
			dx = -dx;
			dy = -dy;
		end
		vx = dx;
		vy = dy;
		rx = (stp * kinv) >>> 30;
		ry = 0;
		for (int i = 0; i < CordicIter; i++) begin
			if (vy >= 0) begin
				nx = vx + asr(vy, i); ny = vy - asr(vx, i);
				vx = nx; vy = ny;
				nx = rx - asr(ry, i); ny = ry + asr(rx, i);
			end else begin
				nx = vx - asr(vy, i); ny = vy + asr(vx, i);
				vx = nx; vy = ny;
				nx = rx + asr(ry, i); ny = ry - asr(rx, i);
			end
			rx = nx;
			ry = ny;
		end
		mag = (longint'(vx < 0 ? 0 : vx) * kinv) >> 30;
		if (mag < longint'(stp)) begin
			mdl_px = mdl_tx;
			mdl_py = mdl_ty;
			mdl_active = 0;
			return ST_REACHED;
		end
		if (flip) begin
			rx = -rx;
			ry = -ry;
		end
		mdl_px = clamp32(mdl_px + rx);
		mdl_py = clamp32(mdl_py + ry);
		return ST_MOVING;
	endfunction

	function automatic out_word_t predict_motion(logic [1:0] m, logic signed [31:0] gx,
			logic signed [31:0] gy);
		out_word_t r;
		logic [2:0] st;
		st = ST_IDLE;
		if (m == MODE_GOAL) begin
			mdl_tx = gx;
			mdl_ty = gy;
			if (mdl_tx == mdl_px && mdl_ty == mdl_py) begin
				mdl_active = 0;
				st = ST_REACHED;
			end else begin
				mdl_active = 1;
				st = ST_ACCEPTED;
			end
		end else if (m == MODE_TICK) begin
			if (mdl_active) st = step_toward_goal();
		end else if (m == MODE_CANCEL && mdl_active) begin
			mdl_active = 0;
			st = ST_PREEMPTED;
		end
		r.pos_x = mdl_px[31:0];
		r.pos_y = mdl_py[31:0];
		r.status = st;
		return r;
	endfunction

	initial begin
		in_ch.valid = 1'b0;
		in_ch.mode = '0;
		in_ch.goal_x = '0;
		in_ch.goal_y = '0;
		out_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > Limit) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= arst_n && ($urandom_range(99) >= rcv_idle);
		end
	end

	always @(posedge clk) begin
		out_word_t e;
		if (out_ch.valid && out_ch.ready) begin
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word x=%h y=%h st=%0d", $time,
					out_ch.pos_x, out_ch.pos_y, out_ch.status);
			end else begin
				e = expected_q.pop_front();
				if (out_ch.pos_x !== e.pos_x || out_ch.pos_y !== e.pos_y
						|| out_ch.status !== e.status) begin
					errors++;
					$display("%0t: mismatch expected x=%h y=%h st=%0d actual x=%h y=%h st=%0d",
						$time, e.pos_x, e.pos_y, e.status,
						out_ch.pos_x, out_ch.pos_y, out_ch.status);
				end
			end
		end
	end

	task automatic send_word(logic [1:0] m, logic signed [31:0] gx, logic signed [31:0] gy);
		if ($urandom_range(99) < snd_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < snd_idle) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= m;
		in_ch.goal_x <= gx;
		in_ch.goal_y <= gy;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		expected_q.push_back(predict_motion(m, gx, gy));
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_step(logic [23:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		mdl_step = v;
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] near_coord();
		return $signed($urandom_range(200000)) - 100000;
	endfunction

	function automatic logic signed [31:0] any_coord();
		case ($urandom_range(3))
			0: return 32'sh7fffffff - $urandom_range(3);
			1: return 32'sh80000000 + $urandom_range(3);
			default: return $urandom;
		endcase
	endfunction

	row_t dir_rows[$];
	out_word_t got_exp;
	logic [23:0] step_set[4];
	logic [1:0] m;
	int n, idx;

	initial begin
		dir_rows = '{
			'{MODE_TICK, 0, 0, 1, 0, 0, ST_IDLE},
			'{MODE_CANCEL, 0, 0, 1, 0, 0, ST_IDLE},
			'{MODE_NONE, 5, 5, 1, 0, 0, ST_IDLE},
			'{MODE_GOAL, 0, 0, 1, 0, 0, ST_REACHED},
			'{MODE_GOAL, 32'sh00010000, 0, 1, 0, 0, ST_ACCEPTED},
			'{MODE_TICK, 0, 0, 0, 0, 0, 0},
			'{MODE_TICK, 0, 0, 0, 0, 0, 0},
			'{MODE_CANCEL, 0, 0, 0, 0, 0, 0},
			'{MODE_CANCEL, 0, 0, 0, 0, 0, 0},
			'{MODE_GOAL, -32'sh00008000, 32'sh00020000, 0, 0, 0, 0},
			'{MODE_GOAL, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0, 0},
			'{MODE_TICK, 0, 0, 0, 0, 0, 0},
			'{MODE_GOAL, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0},
			'{MODE_TICK, 0, 0, 0, 0, 0, 0},
			'{MODE_GOAL, 32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0},
			'{MODE_TICK, 0, 0, 0, 0, 0, 0},
			'{MODE_GOAL, 100, -100, 0, 0, 0, 0},
			'{MODE_TICK, 0, 0, 0, 0, 0, 0},
			'{MODE_TICK, 0, 0, 0, 0, 0, 0},
			'{MODE_NONE, 32'shffffffff, 32'shffffffff, 0, 0, 0, 0}
		};
		mdl_px = 0; mdl_py = 0; mdl_tx = 0; mdl_ty = 0;
		mdl_active = 0;
		mdl_step = StepReset;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			send_word(dir_rows[i].mode, dir_rows[i].gx, dir_rows[i].gy);
			if (dir_rows[i].chk) begin
				got_exp = expected_q[$];
				if (got_exp.pos_x !== dir_rows[i].ex || got_exp.pos_y !== dir_rows[i].ey
						|| got_exp.status !== dir_rows[i].est) begin
					errors++;
					$display("%0t: table row %0d expected st=%0d actual st=%0d", $time, i,
						dir_rows[i].est, got_exp.status);
				end
			end
		end
		drain();
		step_set = '{24'hffffff, 24'd1, 24'd0, 24'd65536};
		for (int ph = 0; ph < 5; ph++) begin
			if (ph < 4) begin
				write_step(ph == 1 ? 24'd1 : step_set[ph]);
			end
			if (ph == 1) begin
				write_step(24'd1);
				send_word(MODE_GOAL, 3, -2);
				send_word(MODE_TICK, 0, 0);
				drain();
				write_step(24'd0);
			end
			snd_idle = (ph < 2) ? 30 : (ph < 4 ? 78 : 0);
			rcv_idle = (ph < 2) ? 78 : (ph < 4 ? 30 : 0);
			if (ph == 4) write_step(24'($urandom_range(2000, 200000)));
			for (int k = 0; k < 250; k++) begin
				if (ph == 4 && k == 40) hold_cycles = 400;
				if ($urandom_range(9) == 0) begin
					m = 2'($urandom_range(3));
					send_word(m, any_coord(), any_coord());
				end else if ($urandom_range(4) == 0) begin
					if ($urandom_range(3) == 0)
						send_word(MODE_GOAL, any_coord(), any_coord());
					else
						send_word(MODE_GOAL, near_coord(), near_coord());
				end else begin
					send_word($urandom_range(7) == 0 ? MODE_CANCEL : MODE_TICK,
						$urandom, $urandom);
				end
			end
			drain();
		end
		if (errors == 0 && expected_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
